// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the peak meter.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pmsd_pkg.sv =====
// Package for the peak meter segment driver: widths, codes, reset values and tables.
// No dependencies; every other file of the block but assert_macros.svh uses it.
`timescale 1ns / 1ps

package pmsd_pkg;

    localparam int LEVEL_W = 16;
    localparam int WIN_W   = 16;
    localparam int SEG_W   = 5;
    localparam int IDX_W   = 2;

    // Number of thresholds below the full-scale point that a bar can reach.
    localparam int MAX_K = (1 << SEG_W) - 1;

    localparam int DB_PER_SEGMENT = 3;

    // Decay factor 13107/16384, applied after every refresh tick.
    localparam int DECAY_SHIFT = 14;
    localparam logic [DECAY_SHIFT-1:0] DECAY_MUL = 14'd13107;

    localparam logic [LEVEL_W-1:0] FULL_SCALE = 16'h8000;

    localparam logic [WIN_W-1:0] WINDOW_LENGTH_RST = 16'd2048;
    localparam logic [SEG_W-1:0] TOTAL_SEGMENTS_RST = 5'd15;
    localparam logic [SEG_W-1:0] SEGMENTS_ABOVE_RST = 5'd2;

    // 10^(-r/40) in millionths, for r = 0..39 half-decibels.
    localparam int unsigned FRAC [40] = '{
        1000000, 944061, 891251, 841395, 794328, 749894, 707946, 668344,
        630957, 595662, 562341, 530884, 501187, 473151, 446684, 421697,
        398107, 375837, 354813, 334965, 316228, 298538, 281838, 266073,
        251189, 237137, 223872, 211349, 199526, 188365, 177828, 167880,
        158489, 149624, 141254, 133352, 125893, 118850, 112202, 105925
    };

    localparam longint unsigned POW10 [5] = '{1, 10, 100, 1000, 10000};

    typedef enum logic
    {
        REQ_SAMPLE = 1'b0,
        REQ_TICK   = 1'b1
    } req_kind_t;

    typedef enum logic [IDX_W-1:0]
    {
        REG_WINDOW_LENGTH  = 2'd0,
        REG_TOTAL_SEGMENTS = 2'd1,
        REG_SEGMENTS_ABOVE = 2'd2
    } cfg_reg_t;

    typedef struct packed
    {
        logic [WIN_W-1:0] window_length;
        logic [SEG_W-1:0] total_segments;
        logic [SEG_W-1:0] segments_above;
    } cfg_t;

endpackage

// ===== sv/pmsd_if.sv =====
// Handshake channels of the peak meter: sample/tick requests, results, register writes.
// Depends on pmsd_pkg.
`timescale 1ns / 1ps

interface pmsd_req_if;
    logic                          valid;
    logic                          ready;
    pmsd_pkg::req_kind_t           req_type;
    logic signed [pmsd_pkg::LEVEL_W-1:0] sample;

    modport source (output valid, output req_type, output sample, input ready);
    modport sink   (input valid, input req_type, input sample, output ready);
endinterface

interface pmsd_res_if;
    logic                        valid;
    logic                        ready;
    logic [pmsd_pkg::SEG_W-1:0]  segments_lit;
    logic                        count_changed;

    modport source (output valid, output segments_lit, output count_changed, input ready);
    modport sink   (input valid, input segments_lit, input count_changed, output ready);
endinterface

interface pmsd_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [pmsd_pkg::IDX_W-1:0]  index;
    logic [pmsd_pkg::WIN_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/pmsd_seg_conv.sv =====
// Level to segment count conversion: parallel compares against 3 dB-step thresholds.
// Depends on pmsd_pkg; the thresholds are worked out at elaboration.
`timescale 1ns / 1ps

module pmsd_seg_conv #(
    parameter int DB_PER_SEGMENT = pmsd_pkg::DB_PER_SEGMENT
) (
    input  logic [pmsd_pkg::LEVEL_W-1:0] level,
    input  pmsd_pkg::cfg_t               cfg,
    output logic [pmsd_pkg::SEG_W-1:0]   count
);

    localparam int SW = pmsd_pkg::SEG_W;

    logic signed [SW:0]            full_idx;
    logic [pmsd_pkg::MAX_K-1:0]    lit;
    logic                          level_nz;

    // Segment index of the full-scale point; negative when red exceeds total.
    assign full_idx = $signed({1'b0, cfg.total_segments})
                    - $signed({1'b0, cfg.segments_above});
    assign level_nz = (level != '0);

    // Threshold k lies (2k+1) half-steps below full scale; the segment k places below
    // the full-scale point is lit when the level reaches it.
    for (genvar k = 0; k < pmsd_pkg::MAX_K; k++) begin : g_thr
        localparam int unsigned H = (2 * k + 1) * DB_PER_SEGMENT;
        localparam longint unsigned RHS = 64'd32768 * pmsd_pkg::FRAC[H % 40];
        localparam longint unsigned DIV = pmsd_pkg::POW10[(H / 40) % 5] * 64'd1000000;
        localparam longint unsigned THR = (H >= 200) ? 64'd1 : (RHS + DIV - 64'd1) / DIV;
        localparam logic [pmsd_pkg::LEVEL_W-1:0] THR_L = pmsd_pkg::LEVEL_W'(THR);
        localparam logic signed [SW:0] K_S = (SW + 1)'(k);

        assign lit[k] = level_nz && (K_S < full_idx) && (level >= THR_L);
    end

    assign count = SW'($countones(lit));

endmodule

// ===== sv/peak_meter_segment_driver.sv =====
// Top level of the peak meter segment driver: windowed peak hold, decay, bar count.
// Depends on pmsd_pkg, the channel interfaces, pmsd_seg_conv and assert_macros.svh.
//
// Channel  Dir  Payload                          Notes
// req      in   req_type, sample                 sample or refresh tick
// res      out  segments_lit, count_changed      one result per tick
// cfg      in   index, data                      always ready
//
// A request is registered on acceptance and processed from the input register; a
// tick result is then held in the result register. One request can be taken every
// cycle while no tick waits. Samples never wait on the result side; a tick waits
// in the input register only while a previous result is still held. Reset clears
// the held level, window state and previous count and loads the register defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module peak_meter_segment_driver #(
    parameter int DB_PER_SEGMENT = pmsd_pkg::DB_PER_SEGMENT
) (
    input  logic         clk,
    input  logic         rst_n,
    pmsd_req_if.sink     req,
    pmsd_res_if.source   res,
    pmsd_cfg_if.sink     cfg
);

    localparam int LW = pmsd_pkg::LEVEL_W;
    localparam int SW = pmsd_pkg::SEG_W;
    localparam int PW = LW + pmsd_pkg::DECAY_SHIFT;

    pmsd_pkg::cfg_t              cfg_reg;

    // Input register
    logic                        s1_valid_reg;
    pmsd_pkg::req_kind_t         s1_type_reg;
    logic signed [LW-1:0]        s1_sample_reg;

    // Meter state
    logic [LW-1:0]               held_level_reg;
    logic [LW-1:0]               held_level_next;
    logic [LW-1:0]               window_peak_reg;
    logic [LW-1:0]               window_peak_next;
    logic [pmsd_pkg::WIN_W-1:0]  window_pos_reg;
    logic [pmsd_pkg::WIN_W-1:0]  window_pos_next;
    logic [SW-1:0]               prev_segments_reg;

    // Result register
    logic                        out_valid_reg;
    logic [SW-1:0]               out_segments_reg;
    logic                        out_changed_reg;

    logic                        out_free;
    logic                        s1_fire;
    logic                        s1_is_tick;
    logic [LW-1:0]               magnitude;
    logic [LW-1:0]               peak_upd;
    logic [pmsd_pkg::WIN_W-1:0]  pos_inc;
    logic [SW-1:0]               seg_count;
    logic [PW-1:0]               decay_prod;

    // Handshakes
    assign out_free   = !out_valid_reg || res.ready;
    assign s1_is_tick = (s1_type_reg == pmsd_pkg::REQ_TICK);
    assign s1_fire    = s1_valid_reg && (!s1_is_tick || out_free);
    assign req.ready  = !s1_valid_reg || s1_fire;
    assign cfg.ready  = 1'b1;

    assign res.valid         = out_valid_reg;
    assign res.segments_lit  = out_segments_reg;
    assign res.count_changed = out_changed_reg;

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_length  <= pmsd_pkg::WINDOW_LENGTH_RST;
            cfg_reg.total_segments <= pmsd_pkg::TOTAL_SEGMENTS_RST;
            cfg_reg.segments_above <= pmsd_pkg::SEGMENTS_ABOVE_RST;
        end
        else if (cfg.valid)
        begin
            unique case (pmsd_pkg::cfg_reg_t'(cfg.index))
                pmsd_pkg::REG_WINDOW_LENGTH:  cfg_reg.window_length  <= cfg.data;
                pmsd_pkg::REG_TOTAL_SEGMENTS: cfg_reg.total_segments <= cfg.data[SW-1:0];
                pmsd_pkg::REG_SEGMENTS_ABOVE: cfg_reg.segments_above <= cfg.data[SW-1:0];
                default: ;
            endcase
        end
    end

    // Input register: loads whenever the stage is empty or moves on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            s1_type_reg   <= req.req_type;
            s1_sample_reg <= req.sample;
        end
    end

    // Sample path: magnitude, running peak and window position.
    assign magnitude = s1_sample_reg[LW-1] ? LW'(-s1_sample_reg) : LW'(s1_sample_reg);
    assign peak_upd  = (magnitude > window_peak_reg) ? magnitude : window_peak_reg;
    assign pos_inc   = window_pos_reg + 1'b1;

    // Tick path: segment count and decayed level.
    pmsd_seg_conv #(
        .DB_PER_SEGMENT (DB_PER_SEGMENT)
    ) u_seg_conv (
        .level (held_level_reg),
        .cfg   (cfg_reg),
        .count (seg_count)
    );

    assign decay_prod = PW'(held_level_reg) * PW'(pmsd_pkg::DECAY_MUL);

    // Next state of the meter for the request in the input register.
    always_comb
    begin
        held_level_next  = held_level_reg;
        window_peak_next = window_peak_reg;
        window_pos_next  = window_pos_reg;
        if (s1_fire)
        begin
            if (s1_is_tick)
            begin
                held_level_next = decay_prod[PW-1:pmsd_pkg::DECAY_SHIFT];
            end
            else if (pos_inc == cfg_reg.window_length)
            begin
                // Window closes: raise the held level to the window peak.
                if (peak_upd > held_level_reg)
                begin
                    held_level_next = peak_upd;
                end
                window_peak_next = '0;
                window_pos_next  = '0;
            end
            else
            begin
                window_peak_next = peak_upd;
                window_pos_next  = pos_inc;
            end
        end
    end

    // Meter state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_level_reg    <= '0;
            window_peak_reg   <= '0;
            window_pos_reg    <= '0;
            prev_segments_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            held_level_reg  <= held_level_next;
            window_peak_reg <= window_peak_next;
            window_pos_reg  <= window_pos_next;
            if (s1_fire && s1_is_tick)
            begin
                prev_segments_reg <= seg_count;
                out_valid_reg     <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_is_tick)
        begin
            out_segments_reg <= seg_count;
            out_changed_reg  <= (seg_count != prev_segments_reg);
        end
    end

    // Checks on the meter state and the result register.
    `ASSERT_SAME(a_held_in_range, 1'b1, held_level_reg <= pmsd_pkg::FULL_SCALE, "held level above full scale")
    `ASSERT_SAME(a_peak_in_range, 1'b1, window_peak_reg <= pmsd_pkg::FULL_SCALE, "window peak above full scale")
    `ASSERT_NEXT(a_tick_gives_result, s1_fire && s1_is_tick, out_valid_reg, "tick produced no result")
    `ASSERT_SAME(a_prev_matches_out, out_valid_reg, out_segments_reg == prev_segments_reg, "previous count out of step")

endmodule
